/* hdl/srs_pkg.sv */
// shared types and constants for the selective repeat sender
// used by srs_ctrl, srs_datapath and selective_repeat_sender
`timescale 1ns / 1ps

package srs_pkg;

  localparam int WINDOW       = 8;
  localparam int SEQ_SPACE    = 16;
  localparam int BUFFER_DEPTH = 64;
  localparam int MAX_PAYLOAD  = 123;

  localparam int ACT_W  = 2;
  localparam int LEN_W  = 7;
  localparam int ACKN_W = 8;
  localparam int KIND_W = 2;
  localparam int SEQ_W  = $clog2(SEQ_SPACE);
  localparam int SLOT_W = $clog2(BUFFER_DEPTH);
  localparam int IF_W   = $clog2(WINDOW + 1);
  localparam int PEND_W = $clog2(BUFFER_DEPTH + 1);
  localparam int WIDX_W = $clog2(WINDOW);

  localparam logic [ACT_W-1:0] ACT_ENQUEUE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ACK      = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TIMEOUT  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_RESERVED = 2'd3;

  localparam logic [KIND_W-1:0] KIND_QUEUED     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TRANSMIT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RETRANSMIT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REJECTED   = 2'd3;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_NEXT,
    IDX_PENDING,
    IDX_IN_FLIGHT
  } idx_sel_t;

  typedef struct packed {
    logic              latch;
    logic              enq_write;
    logic              mark_ack;
    logic              slide_step;
    logic              load_mask;
    logic              clear_mask_bit;
    logic              inc_in_flight;
    idx_sel_t          idx_sel;
    logic              emit;
    logic [KIND_W-1:0] emit_kind;
    logic              emit_timer;
    logic              emit_last;
    logic              emit_len_in;
  } cmd_t;

  typedef struct packed {
    logic is_enq;
    logic is_ack;
    logic is_timeout;
    logic len_zero;
    logic ring_full;
    logic win_open;
    logic if_zero;
    logic ack_ok;
    logic can_slide;
    logic fill_more;
    logic fill_last;
    logic held_zero;
    logic mask_any;
    logic mask_hit;
    logic mask_last;
    logic slid;
  } status_t;

endpackage

/* hdl/selective_repeat_sender.sv */
// selective repeat sender, one request at a time: an enqueue strobes one result; a
// marked ack runs slide steps, then a read and an emit per refilled packet; an ignored
// request strobes nothing; a timeout scans and retransmits each unacked packet in flight
// a read or scan state lies between results, the last as busy falls; cannot be stalled
// synchronous reset clears window state, ack marks and the sequencer
`timescale 1ns / 1ps

module selective_repeat_sender
  import srs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [ACT_W-1:0]  action,
  input  logic [LEN_W-1:0]  payload_length,
  input  logic [ACKN_W-1:0] ack_number,
  input  logic              ack_valid,
  output logic              strobe,
  output logic [KIND_W-1:0] kind,
  output logic [SEQ_W-1:0]  seq_number,
  output logic [SLOT_W-1:0] buffer_slot,
  output logic [LEN_W-1:0]  packet_length,
  output logic              start_timer,
  output logic              last
);

  cmd_t    cmd;
  status_t st;

  srs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  srs_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .action         (action),
    .payload_length (payload_length),
    .ack_number     (ack_number),
    .ack_valid      (ack_valid),
    .strobe         (strobe),
    .kind           (kind),
    .seq_number     (seq_number),
    .buffer_slot    (buffer_slot),
    .packet_length  (packet_length),
    .start_timer    (start_timer),
    .last           (last)
  );

endmodule

/* hdl/srs_datapath.sv */
// window state, ack marks, slot length memory and result registers
// driven by commands from srs_ctrl; depends on srs_pkg
`timescale 1ns / 1ps

module srs_datapath
  import srs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           st,
  input  logic [ACT_W-1:0]  action,
  input  logic [LEN_W-1:0]  payload_length,
  input  logic [ACKN_W-1:0] ack_number,
  input  logic              ack_valid,
  output logic              strobe,
  output logic [KIND_W-1:0] kind,
  output logic [SEQ_W-1:0]  seq_number,
  output logic [SLOT_W-1:0] buffer_slot,
  output logic [LEN_W-1:0]  packet_length,
  output logic              start_timer,
  output logic              last
);

  logic [ACT_W-1:0]  act_q;
  logic [LEN_W-1:0]  len_q;
  logic [ACKN_W-1:0] ackn_q;
  logic              ackv_q;

  logic [SEQ_W-1:0]  base_seq;
  logic [IF_W-1:0]   in_flight;
  logic [PEND_W-1:0] pending_count;
  logic [SLOT_W-1:0] head_slot;
  logic [SEQ_SPACE-1:0] ack_marks;
  logic              slid;
  logic [WINDOW-1:0] mask;
  logic [PEND_W-1:0] idx;

  logic [LEN_W-1:0]  slot_lengths [BUFFER_DEPTH];
  logic [LEN_W-1:0]  rd_len;

  logic [LEN_W-1:0]  len_sat;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] wr_addr;
  logic [SEQ_W-1:0]  seq_cur;
  logic [SEQ_W-1:0]  ack_off;
  logic [PEND_W-1:0] fill_lim;
  logic [WINDOW-1:0] unack;
  logic [WINDOW-1:0] idx_bit;

  assign len_sat = (payload_length > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                          : payload_length;
  assign rd_addr  = head_slot + idx[SLOT_W-1:0];
  assign wr_addr  = head_slot + pending_count[SLOT_W-1:0];
  assign seq_cur  = base_seq + idx[SEQ_W-1:0];
  assign ack_off  = ackn_q[SEQ_W-1:0] - base_seq;
  assign fill_lim = (pending_count < PEND_W'(WINDOW)) ? pending_count : PEND_W'(WINDOW);
  assign idx_bit  = WINDOW'(1) << idx[WIDX_W-1:0];

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      unack[i] = (PEND_W'(i) < PEND_W'(in_flight)) && !ack_marks[base_seq + SEQ_W'(i)];
    end
  end

  always_comb begin
    st.is_enq     = (act_q == ACT_ENQUEUE);
    st.is_ack     = (act_q == ACT_ACK);
    st.is_timeout = (act_q == ACT_TIMEOUT);
    st.len_zero   = (len_q == '0);
    st.ring_full  = (pending_count >= PEND_W'(BUFFER_DEPTH));
    st.win_open   = (in_flight < IF_W'(WINDOW));
    st.if_zero    = (in_flight == '0);
    st.ack_ok     = ackv_q && (ackn_q < ACKN_W'(SEQ_SPACE))
                    && (PEND_W'(ack_off) < PEND_W'(in_flight));
    st.can_slide  = (in_flight != '0) && ack_marks[base_seq];
    st.fill_more  = (PEND_W'(in_flight) < fill_lim);
    st.fill_last  = ((PEND_W'(in_flight) + PEND_W'(1)) >= fill_lim);
    st.held_zero  = (pending_count == '0);
    st.mask_any   = (mask != '0);
    st.mask_hit   = mask[idx[WIDX_W-1:0]];
    st.mask_last  = ((mask & ~idx_bit) == '0);
    st.slid       = slid;
  end

  // request fields held for the whole sequence
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_q  <= action;
      len_q  <= len_sat;
      ackn_q <= ack_number;
      ackv_q <= ack_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_seq      <= '0;
      in_flight     <= '0;
      pending_count <= '0;
      head_slot     <= '0;
      ack_marks     <= '0;
      slid          <= 1'b0;
      mask          <= '0;
      idx           <= '0;
    end else begin
      if (cmd.latch) begin
        slid <= 1'b0;
      end
      if (cmd.enq_write) begin
        pending_count <= pending_count + PEND_W'(1);
      end
      if (cmd.mark_ack) begin
        ack_marks[ackn_q[SEQ_W-1:0]] <= 1'b1;
      end
      if (cmd.slide_step) begin
        ack_marks[base_seq] <= 1'b0;
        in_flight           <= in_flight - IF_W'(1);
        if (pending_count != '0) begin
          pending_count <= pending_count - PEND_W'(1);
        end
        head_slot <= head_slot + SLOT_W'(1);
        base_seq  <= base_seq + SEQ_W'(1);
        slid      <= 1'b1;
      end
      if (cmd.inc_in_flight) begin
        in_flight <= in_flight + IF_W'(1);
      end
      if (cmd.load_mask) begin
        mask <= unack;
      end else if (cmd.clear_mask_bit) begin
        mask <= mask & ~idx_bit;
      end
      case (cmd.idx_sel)
        IDX_HOLD:      idx <= idx;
        IDX_ZERO:      idx <= '0;
        IDX_NEXT:      idx <= idx + PEND_W'(1);
        IDX_PENDING:   idx <= pending_count;
        IDX_IN_FLIGHT: idx <= PEND_W'(in_flight);
        default:       idx <= idx;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq_write) begin
      slot_lengths[wr_addr] <= len_q;
    end
    rd_len <= slot_lengths[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind          <= cmd.emit_kind;
      seq_number    <= seq_cur;
      buffer_slot   <= rd_addr;
      packet_length <= cmd.emit_len_in ? len_q : rd_len;
      start_timer   <= cmd.emit_timer;
      last          <= cmd.emit_last;
    end
  end

`ifndef SYNTHESIS
  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    in_flight <= IF_W'(WINDOW))
    else $error("in-flight count beyond window");
  a_flight_held: assert property (@(posedge clk) disable iff (rst)
    PEND_W'(in_flight) <= pending_count)
    else $error("in-flight count beyond held packets");
  a_slide_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.slide_step |-> (in_flight != '0) && !cmd.inc_in_flight)
    else $error("slide with nothing in flight");
`endif

endmodule

/* hdl/srs_ctrl.sv */
// sequencer for enqueue, ack slide and refill, and timeout retransmit
// issues commands to srs_datapath; depends on srs_pkg
`timescale 1ns / 1ps

module srs_ctrl
  import srs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ENQ_READ,
    S_ENQ_EMIT,
    S_ACK_SLIDE,
    S_FILL_READ,
    S_FILL_EMIT,
    S_TO_SCAN,
    S_TO_EMIT
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [KIND_W-1:0] enq_kind;
  logic [KIND_W-1:0] enq_kind_next;

  always_comb begin
    cmd           = '0;
    cmd.idx_sel   = IDX_HOLD;
    state_next    = state;
    enq_kind_next = enq_kind;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.is_enq) begin
          if (st.len_zero) begin
            state_next = S_IDLE;
          end else begin
            if (st.ring_full) begin
              cmd.idx_sel   = IDX_PENDING;
              enq_kind_next = KIND_REJECTED;
            end else if (st.win_open) begin
              cmd.enq_write = 1'b1;
              cmd.idx_sel   = IDX_IN_FLIGHT;
              enq_kind_next = KIND_TRANSMIT;
            end else begin
              cmd.enq_write = 1'b1;
              cmd.idx_sel   = IDX_PENDING;
              enq_kind_next = KIND_QUEUED;
            end
            state_next = S_ENQ_READ;
          end
        end else if (st.is_ack) begin
          if (st.ack_ok) begin
            cmd.mark_ack = 1'b1;
            state_next   = S_ACK_SLIDE;
          end else begin
            state_next = S_IDLE;
          end
        end else if (st.is_timeout) begin
          if (st.held_zero) begin
            state_next = S_IDLE;
          end else begin
            cmd.load_mask = 1'b1;
            cmd.idx_sel   = IDX_ZERO;
            state_next    = S_TO_SCAN;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ENQ_READ: begin
        state_next = S_ENQ_EMIT;
      end
      S_ENQ_EMIT: begin
        cmd.emit          = 1'b1;
        cmd.emit_kind     = enq_kind;
        cmd.emit_timer    = (enq_kind == KIND_TRANSMIT) && st.if_zero;
        cmd.emit_last     = 1'b1;
        cmd.emit_len_in   = (enq_kind == KIND_REJECTED);
        cmd.inc_in_flight = (enq_kind == KIND_TRANSMIT);
        state_next        = S_IDLE;
      end
      S_ACK_SLIDE: begin
        if (st.can_slide) begin
          cmd.slide_step = 1'b1;
        end else if (st.fill_more) begin
          cmd.idx_sel = IDX_IN_FLIGHT;
          state_next  = S_FILL_READ;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FILL_READ: begin
        state_next = S_FILL_EMIT;
      end
      S_FILL_EMIT: begin
        cmd.emit          = 1'b1;
        cmd.emit_kind     = KIND_TRANSMIT;
        cmd.emit_timer    = st.slid && st.fill_last;
        cmd.emit_last     = st.fill_last;
        cmd.inc_in_flight = 1'b1;
        cmd.idx_sel       = IDX_NEXT;
        state_next        = st.fill_last ? S_IDLE : S_FILL_READ;
      end
      S_TO_SCAN: begin
        if (!st.mask_any) begin
          state_next = S_IDLE;
        end else if (st.mask_hit) begin
          state_next = S_TO_EMIT;
        end else begin
          cmd.idx_sel = IDX_NEXT;
        end
      end
      S_TO_EMIT: begin
        cmd.emit           = 1'b1;
        cmd.emit_kind      = KIND_RETRANSMIT;
        cmd.emit_timer     = 1'b1;
        cmd.emit_last      = st.mask_last;
        cmd.clear_mask_bit = 1'b1;
        cmd.idx_sel        = IDX_NEXT;
        state_next         = st.mask_last ? S_IDLE : S_TO_SCAN;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state    <= state_next;
      busy     <= (state_next != S_IDLE);
      enq_kind <= enq_kind_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");
  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != S_IDLE))
    else $error("busy flag out of step with state");
  a_emit_state: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (state == S_ENQ_EMIT || state == S_FILL_EMIT || state == S_TO_EMIT))
    else $error("result issued outside an emit state");
`endif

endmodule
